// ----- design/efpc_pkg.sv -----
// ----------------------------------------------------------------------------
// efpc_pkg
// Shared constants and codes for the encoder frame parser and corrector.
// ----------------------------------------------------------------------------
package efpc_pkg;

    // Link and table geometry fixed by the field widths
    localparam int unsigned ENCODER_BITS_DEF = 13;
    localparam int unsigned TABLE_DEPTH      = 256;
    localparam int unsigned TABLE_AW         = 8;
    localparam int unsigned TABLE_DW         = 16;
    localparam int unsigned ANGLE_W          = 13;
    localparam int unsigned TEMP_W           = 13;
    localparam int unsigned DEVICE_W         = 6;
    localparam int unsigned POS_W            = 14;

    // Stream payload widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 13;

    // Frame type in bits 7..6 of the sync byte
    localparam logic [1:0] FRAME_DEVICE = 2'b10;
    localparam logic [1:0] FRAME_TEMPPOS = 2'b11;

    // Input item kinds
    typedef enum logic
    {
        FUNC_LINK_BYTE  = 1'b0,
        FUNC_TABLE_WORD = 1'b1
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ANGLE_OFFSET  = 2'd0,
        REG_MIRROR_ENABLE = 2'd1,
        REG_TABLE_ENABLE  = 2'd2
    } cfg_reg_t;

    // Data bytes held after the sync byte before the last one completes a frame
    localparam logic [1:0] LAST_DATA_COUNT = 2'd2;

endpackage

// ----- design/encoder_frame_parse_and_correct.sv -----
// ----------------------------------------------------------------------------
// encoder_frame_parse_and_correct
// Rebuilds sensor link frames and corrects the position with mirror, offset
// and an interpolated correction table held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 content
//  s_*       in         s_tvalid / s_tready       link byte or table word
//  m_*       out        m_tvalid / m_tready       one result per frame
//  cfg_*     in         cfg_valid / cfg_ready     register index and data
//
//  One transaction per cycle on s_* while s_tready is high. A completing frame
//  reads two table entries at the accept edge; the interpolation stage (one
//  multiply) then loads the output register once it is empty or m_tready is
//  high. rst_n clears the parser and the pipeline valids; the table memory
//  is not cleared. s_tready drops only while a result waits in the
//  interpolation stage and the output register is full and stalled.
// ----------------------------------------------------------------------------
module encoder_frame_parse_and_correct
    import efpc_pkg::*;
#(
    parameter int unsigned ENCODER_BITS = ENCODER_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // rx_byte[7:0], table_index[15:8],
                                            // table_word[31:16]
    input  logic                 s_tuser,   // func[0]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // device_kind[5:0], temperature[18:6],
                                            // angle_raw[31:19], angle[44:32],
                                            // data_valid[45], zero[47:46]
    output logic                 m_tuser,   // frame_kind[0]

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int unsigned EB   = ENCODER_BITS;
    localparam int unsigned FRAC = EB - TABLE_AW;
    localparam int unsigned PW   = TABLE_DW + 2 + FRAC;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_DAT_W-1:0] angle_offset_reg;
    logic                 mirror_enable_reg;
    logic                 table_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_offset_reg  <= '0;
            mirror_enable_reg <= 1'b0;
            table_enable_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ANGLE_OFFSET:  angle_offset_reg  <= cfg_data;
                REG_MIRROR_ENABLE: mirror_enable_reg <= cfg_data[0];
                REG_TABLE_ENABLE:  table_enable_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [7:0]          rx_byte;
    logic [TABLE_AW-1:0] table_index;
    logic [TABLE_DW-1:0] table_word;
    func_t               func;
    logic                s_accept;

    assign rx_byte     = s_tdata[7:0];
    assign table_index = s_tdata[15:8];
    assign table_word  = s_tdata[31:16];
    assign func        = func_t'(s_tuser);
    assign s_accept    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Frame parser
    // ------------------------------------------------------------------
    logic [1:0]          frame_count_reg, frame_count_next;
    logic                in_frame_reg, in_frame_next;
    logic [7:0]          held0_reg, held0_next;
    logic [7:0]          held1_reg, held1_next;
    logic [7:0]          held2_reg, held2_next;
    logic [DEVICE_W-1:0] last_device_reg, last_device_next;
    logic [TEMP_W-1:0]   last_temp_reg, last_temp_next;
    logic [POS_W-1:0]    last_pos_reg, last_pos_next;
    logic                frame_done;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        in_frame_next    = in_frame_reg;
        held0_next       = held0_reg;
        held1_next       = held1_reg;
        held2_next       = held2_reg;
        last_device_next = last_device_reg;
        last_temp_next   = last_temp_reg;
        last_pos_next    = last_pos_reg;
        frame_done       = 1'b0;
        if (s_accept && func == FUNC_LINK_BYTE)
        begin
            if (rx_byte[7])
            begin
                // sync byte always restarts the frame
                in_frame_next    = 1'b1;
                frame_count_next = 2'd0;
                held0_next       = rx_byte;
            end
            else if (in_frame_reg)
            begin
                if (frame_count_reg != LAST_DATA_COUNT)
                begin
                    if (frame_count_reg == 2'd0)
                        held1_next = rx_byte;
                    else
                        held2_next = rx_byte;
                    frame_count_next = frame_count_reg + 2'd1;
                end
                else
                begin
                    frame_done       = 1'b1;
                    in_frame_next    = 1'b0;
                    frame_count_next = 2'd0;
                    if (held0_reg[7:6] == FRAME_DEVICE)
                        last_device_next = held0_reg[5:0];
                    else
                    begin
                        last_temp_next = {held0_reg[5:0], held1_reg[6:0]};
                        last_pos_next  = {held2_reg[6:0], rx_byte[6:0]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            in_frame_reg    <= 1'b0;
            held0_reg       <= '0;
            held1_reg       <= '0;
            held2_reg       <= '0;
            last_device_reg <= '0;
            last_temp_reg   <= '0;
            last_pos_reg    <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            in_frame_reg    <= in_frame_next;
            held0_reg       <= held0_next;
            held1_reg       <= held1_next;
            held2_reg       <= held2_next;
            last_device_reg <= last_device_next;
            last_temp_reg   <= last_temp_next;
            last_pos_reg    <= last_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Mirror and offset, table addresses
    // ------------------------------------------------------------------
    logic [EB-1:0]       pos_enc;
    logic [EB-1:0]       raw_enc;
    logic [EB-1:0]       adj_enc;
    logic [TABLE_AW-1:0] rd_addr0;
    logic [TABLE_AW-1:0] rd_addr1;

    assign pos_enc  = EB'(last_pos_next);
    assign raw_enc  = mirror_enable_reg ? (EB'(0) - pos_enc) : pos_enc;
    assign adj_enc  = raw_enc - EB'(angle_offset_reg);
    assign rd_addr0 = adj_enc[EB-1:FRAC];
    assign rd_addr1 = rd_addr0 + TABLE_AW'(1);

    // ------------------------------------------------------------------
    // Correction table memory: one write port, two read ports
    // ------------------------------------------------------------------
    logic [TABLE_DW-1:0] table_mem [TABLE_DEPTH];
    logic [TABLE_DW-1:0] rd0_reg;
    logic [TABLE_DW-1:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept && func == FUNC_TABLE_WORD)
            table_mem[table_index] <= table_word;
        if (frame_done)
        begin
            rd0_reg <= table_mem[rd_addr0];
            rd1_reg <= table_mem[rd_addr1];
        end
    end

    // ------------------------------------------------------------------
    // Interpolation stage
    // ------------------------------------------------------------------
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_kind_reg;
    logic [DEVICE_W-1:0] s1_dev_reg;
    logic [TEMP_W-1:0]   s1_temp_reg;
    logic [EB-1:0]       s1_raw_reg;
    logic [EB-1:0]       s1_adj_reg;
    logic                s1_go;

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            s1_kind_reg <= held0_reg[6];
            s1_dev_reg  <= last_device_next;
            s1_temp_reg <= last_temp_next;
            s1_raw_reg  <= raw_enc;
            s1_adj_reg  <= adj_enc;
        end
    end

    logic signed [TABLE_DW-1:0] o0_s;
    logic signed [TABLE_DW-1:0] o1_s;
    logic signed [TABLE_DW:0]   diff_s;
    logic signed [FRAC:0]       frac_s;
    logic signed [PW-1:0]       prod_s;
    logic signed [PW-1:0]       step_s;
    logic signed [PW-1:0]       corr_s;
    logic [EB-1:0]              angle_enc;

    always_comb
    begin
        o0_s   = $signed(rd0_reg);
        o1_s   = $signed(rd1_reg);
        diff_s = $signed({o1_s[TABLE_DW-1], o1_s}) - $signed({o0_s[TABLE_DW-1], o0_s});
        frac_s = $signed({1'b0, s1_adj_reg[FRAC-1:0]});
        prod_s = PW'(diff_s) * PW'(frac_s);
        // arithmetic shift gives the floor of the scaled step
        step_s = prod_s >>> FRAC;
        corr_s = PW'(o0_s) + step_s;
        if (table_enable_reg)
            angle_enc = s1_adj_reg + corr_s[EB-1:0];
        else
            angle_enc = s1_adj_reg;
    end

    // ------------------------------------------------------------------
    // Output register and flow control
    // ------------------------------------------------------------------
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_kind_reg;

    assign s1_go    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (frame_done)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (s1_go)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            m_kind_reg <= s1_kind_reg;
            m_data_reg <= {2'b00,
                           1'b1,
                           ANGLE_W'(angle_enc),
                           ANGLE_W'(s1_raw_reg),
                           s1_temp_reg,
                           s1_dev_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule
